### hw/rtl/assert_macros.svh
// assertion macros shared by the deque rtl
// every property is sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CDQ_ASSERT_NEVER(lbl, cond, msg) \
  `CDQ_ASSERT(lbl, !(cond), msg)

`endif

### hw/rtl/cdq_pkg.sv
// shared types and constants for the circular deque
// no dependencies; used by the channel interfaces and circular_deque
package cdq_pkg;

  localparam int unsigned CDQ_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned STATUS_W     = 2;

  // operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_PEEK_FRONT = 3'd4
  } kind_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

### hw/rtl/cdq_if.sv
// valid/ready channel interfaces for the deque request and result beats
// depends on cdq_pkg for field widths
interface cdq_in_if
  import cdq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, kind, data_in, input ready);
  modport sink   (input valid, kind, data_in, output ready);
endinterface

interface cdq_out_if
  import cdq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data_out;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, status, data_out, is_empty, is_full, input ready);
  modport sink   (input valid, status, data_out, is_empty, is_full, output ready);
endinterface

### hw/rtl/cdq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; read data holds until the next read
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/circular_deque.sv
// circular deque top level: index control, result register and ring ram
// depends on cdq_pkg, cdq_if.sv, cdq_ram and assert_macros.svh
//
// Usage:
//   in_i carries one operation per beat: kind (push front, push rear,
//   pop front, pop rear, peek front) and data_in, the word to push.
//   out_o returns exactly one result beat per request: status, the popped
//   or peeked word in data_out (zero otherwise) and the is_empty / is_full
//   flags that hold after the operation.
//   Timing: an accepted request moves the sequencer from S_IDLE to S_RD,
//   where the registered ram read data is ready, and its result is loaded
//   into the output register once that register is free. in_i.ready is
//   low in S_RD, so no new request is taken until the last one has left it.
//   Head and tail indexes move at acceptance; the ram is written in the
//   acceptance cycle or read for the next one.
//   Reset: the deque is empty, both indexes are zero, no result is pending.
//   Ram contents are not cleared; only written slots are ever read.
//   Receiver stall: one result waits in the output register while the next
//   request is accepted; that request then holds in its read cycle until
//   the output register frees up.
`include "assert_macros.svh"

module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned CAPACITY = CDQ_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  typedef enum logic {
    S_IDLE,
    S_RD
  } state_e;

  // bookkeeping carried from acceptance to the result
  typedef struct packed {
    status_e status;
    logic    use_rd;
    logic    empty;
    logic    full;
  } pend_t;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic               empty_q, empty_d;
  pend_t              pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [DATA_W-1:0]  out_data_q;
  logic               out_empty_q, out_full_q;

  logic               in_acc;
  logic               out_load;
  logic               full_now;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  logic [DATA_W-1:0]  rdata;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign full_now   = !empty_q && (wrap_inc(tail_q) == head_q);
  assign out_load   = (state_q == S_RD) && (!out_valid_q || out_o.ready);

  // operation decode and index update at acceptance
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    we      = 1'b0;
    waddr   = '0;
    re      = 1'b0;
    raddr   = head_q;
    pend_d  = pend_q;
    if (in_acc) begin
      pend_d.status = ST_DONE;
      pend_d.use_rd = 1'b0;
      unique case (in_i.kind)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          if (full_now) begin
            pend_d.status = ST_FULL;
          end else if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
            we      = 1'b1;
            waddr   = '0;
          end else if (in_i.kind == KIND_PUSH_FRONT) begin
            head_d = wrap_dec(head_q);
            we     = 1'b1;
            waddr  = wrap_dec(head_q);
          end else begin
            tail_d = wrap_inc(tail_q);
            we     = 1'b1;
            waddr  = wrap_inc(tail_q);
          end
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          if (empty_q) begin
            pend_d.status = ST_EMPTY;
          end else begin
            re            = 1'b1;
            raddr         = (in_i.kind == KIND_POP_FRONT) ? head_q : tail_q;
            pend_d.use_rd = 1'b1;
            if (head_q == tail_q) begin
              empty_d = 1'b1;
              head_d  = '0;
              tail_d  = '0;
            end else if (in_i.kind == KIND_POP_FRONT) begin
              head_d = wrap_inc(head_q);
            end else begin
              tail_d = wrap_dec(tail_q);
            end
          end
        end
        KIND_PEEK_FRONT: begin
          if (empty_q) begin
            pend_d.status = ST_EMPTY;
          end else begin
            re            = 1'b1;
            raddr         = head_q;
            pend_d.use_rd = 1'b1;
          end
        end
        default: begin
        end
      endcase
      pend_d.empty = empty_d;
      pend_d.full  = !empty_d && (wrap_inc(tail_d) == head_d);
    end
  end

  // sequencer and result handshake
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pending bookkeeping and result payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_status_q <= pend_q.status;
      out_data_q   <= pend_q.use_rd ? rdata : '0;
      out_empty_q  <= pend_q.empty;
      out_full_q   <= pend_q.full;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.data_in),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.data_out = out_data_q;
  assign out_o.is_empty = out_empty_q;
  assign out_o.is_full  = out_full_q;

  // checks on index and sequencer consistency
  `CDQ_ASSERT(a_empty_idx_zero, empty_q |-> (head_q == '0 && tail_q == '0), "empty with nonzero index")
  `CDQ_ASSERT(a_acc_to_read, in_acc |=> (state_q == S_RD), "accepted beat did not enter read cycle")
  `CDQ_ASSERT(a_load_only_in_read, out_load |-> (state_q == S_RD), "result loaded outside read cycle")
  `CDQ_ASSERT_NEVER(a_no_ram_collide, we && re, "ram read and write in the same cycle")

endmodule
